FILE: rtl/depth_pixel_backprojection_unit_macros.svh
// Assertion macros shared by the back-projection RTL.
// No dependencies; included by modules that carry assertions.
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPBU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dpbu_pkg.sv
// Shared constants, register indexes and types of the depth back-projection unit.
// No dependencies.
`default_nettype none

package dpbu_pkg;

    localparam int P_MAX_DIM = 4096;
    localparam int CNT_W     = $clog2(P_MAX_DIM);

    localparam int SIZE_W    = 13;
    localparam int DEPTH_W   = 16;
    localparam int SCALE_W   = 24;
    localparam int CTR_W     = 16;
    localparam int INV_W     = 24;
    localparam int Z_W       = 32;
    localparam int RES_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int POS_W     = CNT_W + 4;
    localparam int OFF_W     = ((POS_W > CTR_W) ? POS_W : CTR_W) + 1;
    localparam int MAG_W     = OFF_W - 1;
    localparam int A_W       = MAG_W + INV_W;
    localparam int ALO_W     = 32;
    localparam int AHI_W     = A_W - ALO_W;
    localparam int LO_W      = ALO_W + Z_W;
    localparam int HI_W      = AHI_W + Z_W;
    localparam int FRAC_W    = 28;
    localparam int Q_W       = HI_W + 4;
    localparam int ZP_W      = DEPTH_W + SCALE_W;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = OUTQ_AW + 1;
    localparam int PIPE_STAGES = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd6;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [SCALE_W-1:0] depth_scale;
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic [INV_W-1:0]   inv_focal_x;
        logic [INV_W-1:0]   inv_focal_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        image_width:  13'd8,
        image_height: 13'd8,
        depth_scale:  24'd16777,
        center_x:     16'd56,
        center_y:     16'd56,
        inv_focal_x:  24'd0,
        inv_focal_y:  24'd0
    };

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
    } t_cmd_push;

    typedef struct packed {
        logic signed [RES_W-1:0] x;
        logic signed [RES_W-1:0] y;
        logic [Z_W-1:0]          z;
    } t_point;

endpackage

`default_nettype wire

FILE: rtl/dpbu_front.sv
// Front end: pixel acceptance, raster counters and pixel classification.
// Depends on dpbu_pkg.
`default_nettype none

module dpbu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpbu_pkg::t_cfg    i_cfg,
    input  wire logic              i_push,
    input  wire logic [15:0]       i_depth_sample,
    input  wire logic              i_cmdq_full,
    output dpbu_pkg::t_cmd_push    o_cmd_push
);
    import dpbu_pkg::*;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W:0]   col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic             accept, calib_ok;

    assign accept   = i_push && !i_cmdq_full;
    assign calib_ok = (i_cfg.inv_focal_x != '0) && (i_cfg.inv_focal_y != '0);

    assign col_inc  = {1'b0, r_col} + (CNT_W+1)'(1);
    assign row_inc  = {1'b0, r_row} + (CNT_W+1)'(1);
    assign col_wrap = (32'(col_inc) >= 32'(i_cfg.image_width)) ||
                      (32'(col_inc) >= 32'(P_MAX_DIM));
    assign row_wrap = (32'(row_inc) >= 32'(i_cfg.image_height)) ||
                      (32'(row_inc) >= 32'(P_MAX_DIM));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_col = col_wrap ? '0 : col_inc[CNT_W-1:0];
            if (col_wrap) begin
                n_row = row_wrap ? '0 : row_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_cmd_push.valid     = accept && calib_ok && (i_depth_sample != '0);
    assign o_cmd_push.cmd.depth = i_depth_sample;
    assign o_cmd_push.cmd.col   = r_col;
    assign o_cmd_push.cmd.row   = r_row;

endmodule

`default_nettype wire

FILE: rtl/dpbu_cmd_queue.sv
// Short command queue between the front end and the arithmetic back end.
// Depends on dpbu_pkg.
`default_nettype none

module dpbu_cmd_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dpbu_pkg::t_cmd_push i_push,
    output logic                     o_full,
    output logic                     o_valid,
    output dpbu_pkg::t_cmd           o_cmd,
    input  wire logic                i_pop
);
    import dpbu_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dpbu_back.sv
// Back end: four-stage projection pipeline and credit-guarded result queue.
// Depends on dpbu_pkg and the assertion macro header.
`default_nettype none
`include "depth_pixel_backprojection_unit_macros.svh"

module dpbu_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpbu_pkg::t_cfg    i_cfg,
    input  wire logic              i_cmd_valid,
    input  wire dpbu_pkg::t_cmd    i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic signed [47:0]     o_point_x,
    output logic signed [47:0]     o_point_y,
    output logic [31:0]            o_point_z
);
    import dpbu_pkg::*;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_off;

    function automatic t_off offset_mag(input logic [CNT_W-1:0] pos,
                                        input logic [CTR_W-1:0] ctr);
        logic [OFF_W-1:0] diff;
        t_off             res;
        diff    = OFF_W'({pos, 4'b0000}) - OFF_W'(ctr);
        res.neg = diff[OFF_W-1];
        res.mag = res.neg ? MAG_W'(-diff) : MAG_W'(diff);
        return res;
    endfunction

    logic [OUTQ_CNT_W-1:0]  r_credit;
    logic                   issue, out_pop, out_push;
    logic [PIPE_STAGES-1:0] r_vld;

    t_off             off_x, off_y;
    logic [ZP_W-1:0]  zprod;

    t_off             r_s1_ox, r_s1_oy;
    logic [Z_W-1:0]   r_s1_z;

    logic [A_W-1:0]   r_s2_ax, r_s2_ay;
    logic             r_s2_nx, r_s2_ny;
    logic [Z_W-1:0]   r_s2_z;

    logic [LO_W-1:0]  r_s3_lox, r_s3_loy;
    logic [HI_W-1:0]  r_s3_hix, r_s3_hiy;
    logic             r_s3_nx, r_s3_ny;
    logic [Z_W-1:0]   r_s3_z;

    logic [Q_W-1:0]   r_s4_qx, r_s4_qy;
    logic             r_s4_rx, r_s4_ry, r_s4_nx, r_s4_ny;
    logic [Z_W-1:0]   r_s4_z;

    logic [RES_W-1:0] qx_ext, qy_ext;
    t_point           wr_point;

    t_point                r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]    r_owp, r_orp;
    logic [OUTQ_CNT_W-1:0] r_ocnt;

    assign issue     = i_cmd_valid && (r_credit < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign o_cmd_pop = issue;
    assign out_push  = r_vld[PIPE_STAGES-1];
    assign out_pop   = i_pop && !o_empty;

    assign off_x = offset_mag(i_cmd.col, i_cfg.center_x);
    assign off_y = offset_mag(i_cmd.row, i_cfg.center_y);
    assign zprod = ZP_W'(i_cmd.depth) * ZP_W'(i_cfg.depth_scale);

    always_ff @(posedge i_clk) begin
        r_s1_ox  <= off_x;
        r_s1_oy  <= off_y;
        r_s1_z   <= zprod[Z_W+7:8];

        r_s2_ax  <= A_W'(r_s1_ox.mag) * A_W'(i_cfg.inv_focal_x);
        r_s2_ay  <= A_W'(r_s1_oy.mag) * A_W'(i_cfg.inv_focal_y);
        r_s2_nx  <= r_s1_ox.neg;
        r_s2_ny  <= r_s1_oy.neg;
        r_s2_z   <= r_s1_z;

        r_s3_lox <= LO_W'(r_s2_ax[ALO_W-1:0]) * LO_W'(r_s2_z);
        r_s3_loy <= LO_W'(r_s2_ay[ALO_W-1:0]) * LO_W'(r_s2_z);
        r_s3_hix <= HI_W'(r_s2_ax[A_W-1:ALO_W]) * HI_W'(r_s2_z);
        r_s3_hiy <= HI_W'(r_s2_ay[A_W-1:ALO_W]) * HI_W'(r_s2_z);
        r_s3_nx  <= r_s2_nx;
        r_s3_ny  <= r_s2_ny;
        r_s3_z   <= r_s2_z;

        r_s4_qx  <= Q_W'({r_s3_hix, 4'b0000}) + Q_W'(r_s3_lox[LO_W-1:FRAC_W]);
        r_s4_qy  <= Q_W'({r_s3_hiy, 4'b0000}) + Q_W'(r_s3_loy[LO_W-1:FRAC_W]);
        r_s4_rx  <= (r_s3_lox[FRAC_W-1:0] != '0);
        r_s4_ry  <= (r_s3_loy[FRAC_W-1:0] != '0);
        r_s4_nx  <= r_s3_nx;
        r_s4_ny  <= r_s3_ny;
        r_s4_z   <= r_s3_z;
    end

    // floor of a negative quotient: -(q + rem) = ~q + !rem
    assign qx_ext = RES_W'(r_s4_qx);
    assign qy_ext = RES_W'(r_s4_qy);
    assign wr_point.x = $signed(r_s4_nx ? (~qx_ext + RES_W'(!r_s4_rx)) : qx_ext);
    assign wr_point.y = $signed(r_s4_ny ? (~qy_ext + RES_W'(!r_s4_ry)) : qy_ext);
    assign wr_point.z = r_s4_z;

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_mem[r_owp] <= wr_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_credit <= '0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_vld    <= {r_vld[PIPE_STAGES-2:0], issue};
            r_credit <= r_credit + OUTQ_CNT_W'(issue) - OUTQ_CNT_W'(out_pop);
            if (out_push) begin
                r_owp <= r_owp + OUTQ_AW'(1);
            end
            if (out_pop) begin
                r_orp <= r_orp + OUTQ_AW'(1);
            end
            r_ocnt <= r_ocnt + OUTQ_CNT_W'(out_push) - OUTQ_CNT_W'(out_pop);
        end
    end

    assign o_empty   = (r_ocnt == '0);
    assign o_point_x = r_mem[r_orp].x;
    assign o_point_y = r_mem[r_orp].y;
    assign o_point_z = r_mem[r_orp].z;

    `DPBU_ASSERT_NOW(a_credit_bound, i_clk, i_rst_n, 1'b1,
        r_credit <= OUTQ_CNT_W'(OUTQ_DEPTH), "credit count above result queue depth")
    `DPBU_ASSERT_NOW(a_credit_match, i_clk, i_rst_n, 1'b1,
        32'(r_credit) == 32'(r_ocnt) + 32'($countones(r_vld)),
        "credits differ from queued plus in-flight results")
    `DPBU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, out_push,
        r_ocnt < OUTQ_CNT_W'(OUTQ_DEPTH) || out_pop, "result queue overflow")
    `DPBU_ASSERT_NEXT(a_pop_credit, i_clk, i_rst_n, out_pop && !issue,
        r_credit == $past(r_credit) - OUTQ_CNT_W'(1), "pop did not return a credit")

endmodule

`default_nettype wire

FILE: rtl/depth_pixel_backprojection_unit.sv
// Top level of the depth back-projection unit: configuration registers and
// the front end, command queue and back end. Depends on dpbu_pkg and its submodules.
//
// Takes one depth pixel per cycle in raster order while full is low and
// returns one point per nonzero pixel while both reciprocal focal lengths
// are nonzero; other pixels only advance the column and row counters. A
// taken pixel is queued, then passes four registered stages (depth scale
// and principal point offset, reciprocal multiply, split 32x32 and 8x32
// partial products with z, recombination) before it is written into an
// eight-entry result queue. The back end issues from the four-entry
// command queue only while the result queue has a free credit, so the
// sustained rate is one pixel per cycle as long as results are popped, and
// full rises once both queues have filled. Configuration writes are always
// accepted and must be made while idle.
`default_nettype none

module depth_pixel_backprojection_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [15:0]        i_depth_sample,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [47:0]      o_point_x,
    output logic signed [47:0]      o_point_y,
    output logic [31:0]             o_point_z
);
    import dpbu_pkg::*;

    t_cfg      r_cfg, n_cfg;
    t_cmd_push cmd_push;
    t_cmd      q_cmd;
    logic      q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  n_cfg.image_width  = i_cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = i_cfg_data[SIZE_W-1:0];
                REG_DEPTH_SCALE:  n_cfg.depth_scale  = i_cfg_data[SCALE_W-1:0];
                REG_CENTER_X:     n_cfg.center_x     = i_cfg_data[CTR_W-1:0];
                REG_CENTER_Y:     n_cfg.center_y     = i_cfg_data[CTR_W-1:0];
                REG_INV_FOCAL_X:  n_cfg.inv_focal_x  = i_cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:  n_cfg.inv_focal_y  = i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dpbu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .i_depth_sample (i_depth_sample),
        .i_cmdq_full    (full),
        .o_cmd_push     (cmd_push)
    );

    dpbu_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    dpbu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z)
    );

endmodule

`default_nettype wire

FILE: test/tb_depth_pixel_backprojection_unit.sv
// Testbench for depth_pixel_backprojection_unit: drives depth pixels through the push/full
// side, predicts each 3-D point in fixed point and checks every popped point field by field.
// Depends on dpbu_pkg and the RTL of the unit; needs no files or arguments.
`default_nettype none

module tb_depth_pixel_backprojection_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dpbu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [15:0]        i_depth_sample = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [47:0] o_point_x;
    logic signed [47:0] o_point_y;
    logic [31:0]        o_point_z;

    t_cfg   model_cfg = CFG_RESET;
    int     col_pos = 0;
    int     row_pos = 0;
    t_point pending_points[$];

    logic   calm = 1'b0;
    logic   hold_on = 1'b0;
    event   receiver_hold;
    int     fails = 0;
    int     pixels_sent = 0;
    int     points_checked = 0;
    int     cfg_writes = 0;

    depth_pixel_backprojection_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_depth_sample (i_depth_sample),
        .empty          (empty),
        .pop            (pop),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_z      (o_point_z)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [47:0] project_axis(input int pos, input int center,
                                                        input logic [23:0] inv,
                                                        input logic [31:0] z);
        logic signed [95:0] off_w;
        logic signed [95:0] inv_w;
        logic signed [95:0] z_w;
        logic signed [95:0] prod;
        off_w = pos * 16 - center;
        inv_w = {72'd0, inv};
        z_w   = {64'd0, z};
        prod  = off_w * inv_w * z_w;
        prod  = prod >>> 28;
        return prod[47:0];
    endfunction

    function automatic int next_count(input int count, input int limit);
        int nxt;
        nxt = count + 1;
        if (nxt >= limit || nxt >= P_MAX_DIM) begin
            return 0;
        end
        return nxt;
    endfunction

    task automatic predict_pixel(input logic [15:0] depth);
        logic [39:0] z_full;
        t_point      pt;
        if (depth != 0 && model_cfg.inv_focal_x != 0 && model_cfg.inv_focal_y != 0) begin
            z_full = depth * model_cfg.depth_scale;
            pt.z = z_full[39:8];
            pt.x = project_axis(col_pos, model_cfg.center_x, model_cfg.inv_focal_x, pt.z);
            pt.y = project_axis(row_pos, model_cfg.center_y, model_cfg.inv_focal_y, pt.z);
            pending_points.insert(pending_points.size(), pt);
        end
        col_pos = next_count(col_pos, model_cfg.image_width);
        if (col_pos == 0) begin
            row_pos = next_count(row_pos, model_cfg.image_height);
        end
    endtask

    task automatic send_depth(input logic [15:0] depth);
        if (!calm && $urandom_range(0, 99) < 6) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_depth_sample <= depth;
        do @(posedge i_clk); while (full);
        predict_pixel(depth);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH: begin
                model_cfg.image_width = value[SIZE_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                model_cfg.image_height = value[SIZE_W-1:0];
            end
            REG_DEPTH_SCALE: begin
                model_cfg.depth_scale = value[SCALE_W-1:0];
            end
            REG_CENTER_X: begin
                model_cfg.center_x = value[CTR_W-1:0];
            end
            REG_CENTER_Y: begin
                model_cfg.center_y = value[CTR_W-1:0];
            end
            REG_INV_FOCAL_X: begin
                model_cfg.inv_focal_x = value[INV_W-1:0];
            end
            REG_INV_FOCAL_Y: begin
                model_cfg.inv_focal_y = value[INV_W-1:0];
            end
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    task automatic apply_config(input int width, input int height, input int scale,
                                input int cx, input int cy, input int inv_x, input int inv_y);
        write_reg(REG_IMAGE_WIDTH, 24'(width));
        write_reg(REG_IMAGE_HEIGHT, 24'(height));
        write_reg(REG_DEPTH_SCALE, 24'(scale));
        write_reg(REG_CENTER_X, 24'(cx));
        write_reg(REG_CENTER_Y, 24'(cy));
        write_reg(REG_INV_FOCAL_X, 24'(inv_x));
        write_reg(REG_INV_FOCAL_Y, 24'(inv_y));
        i_cfg_valid <= 1'b0;
    endtask

    // drain outstanding points, then let pixels without a point leave the pipeline
    task automatic settle();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (pending_points.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : receive_points
        t_point want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_points.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time,
                             o_point_x, o_point_y, o_point_z);
                end else begin
                    want = pending_points.pop_front();
                    points_checked++;
                    if (o_point_x !== want.x) begin
                        fails++;
                        $display("%0t: point_x expected %0d actual %0d", $time, want.x,
                                 o_point_x);
                    end
                    if (o_point_y !== want.y) begin
                        fails++;
                        $display("%0t: point_y expected %0d actual %0d", $time, want.y,
                                 o_point_y);
                    end
                    if (o_point_z !== want.z) begin
                        fails++;
                        $display("%0t: point_z expected %0d actual %0d", $time, want.z,
                                 o_point_z);
                    end
                end
            end
            if (hold_on) begin
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    initial begin
        forever begin
            @(receiver_hold);
            hold_on <= 1'b1;
            repeat (250) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    task automatic test_invalid_calibration();
        send_depth(16'd1);
        send_depth(16'hFFFF);
        send_depth(16'h5A5A);
        settle();
        write_reg(REG_INV_FOCAL_X, 24'd1);
        i_cfg_valid <= 1'b0;
        send_depth(16'd3);
        send_depth(16'hFFFF);
        settle();
        write_reg(REG_INV_FOCAL_Y, 24'd1);
        i_cfg_valid <= 1'b0;
        send_depth(16'd1);
        send_depth(16'hFFFF);
        settle();
    endtask

    task automatic test_field_extremes();
        logic [15:0] picks [8];
        picks = '{16'hFFFF, 16'd1, 16'd0, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'd2};
        apply_config(8, 8, 24'hFFFFFF, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
        foreach (picks[i]) send_depth(picks[i]);
        settle();
        apply_config(8, 8, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        foreach (picks[i]) send_depth(picks[i]);
        settle();
        // small reciprocals leave a remainder: negative offsets round down
        apply_config(5, 3, 16777, 37, 21, 1, 3);
        for (int i = 0; i < 8; i++) send_depth(16'(i * 997 + 1));
        settle();
    endtask

    task automatic test_zero_scale();
        apply_config(4, 4, 0, 20, 20, 24'h123456, 24'h654321);
        send_depth(16'hFFFF);
        send_depth(16'd1);
        send_depth(16'h1234);
        settle();
    endtask

    task automatic test_unknown_index();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        i_cfg_valid <= 1'b0;
        send_depth(16'd100);
        send_depth(16'hFFFF);
        settle();
    endtask

    task automatic test_size_change();
        apply_config(16, 4, 16777, 128, 32, 24'h00C000, 24'h00C000);
        for (int i = 0; i < 12; i++) send_depth(16'(500 + i));
        settle();
        write_reg(REG_IMAGE_WIDTH, 24'd4);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 6; i++) send_depth(16'(700 + i));
        settle();
        write_reg(REG_IMAGE_WIDTH, 24'd0);
        write_reg(REG_IMAGE_HEIGHT, 24'd0);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 4; i++) send_depth(16'(900 + i));
        settle();
    endtask

    // sizes beyond the counter range, one frame row-major and one column-only
    task automatic test_max_dimension();
        apply_config(8191, 4097, 24'hFFFFFF, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < 20; i++) send_depth(16'hFFFF);
        settle();
        apply_config(0, 4097, 24'hFFFFFF, 16'hFFFF, 0, 24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < 20; i++) send_depth(16'hFFFF);
        settle();
    endtask

    task automatic test_full_stall();
        apply_config(6, 5, 24'h00FFFF, 40, 30, 24'h0F0000, 24'h00F000);
        -> receiver_hold;
        for (int i = 0; i < 64; i++) send_depth(16'($urandom_range(1, 65535)));
        settle();
    endtask

    task automatic test_random_frames();
        int          width;
        int          height;
        int          roll;
        logic [15:0] depth;
        for (int phase = 0; phase < 8; phase++) begin
            width  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                  : $urandom_range(0, 8191);
            height = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                  : $urandom_range(0, 8191);
            case (phase)
                0: begin
                    apply_config(1, 1, 1, 0, 0, 1, 1);
                end
                1: begin
                    apply_config(8191, 8191, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                                 24'hFFFFFF, 24'hFFFFFF);
                end
                5: begin
                    apply_config(width, height, $urandom_range(0, 24'hFFFFFF),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 0, $urandom_range(1, 24'hFFFFFF));
                end
                default: begin
                    apply_config(width, height, $urandom_range(0, 24'hFFFFFF),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(1, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF));
                end
            endcase
            calm = (phase == 3);
            for (int i = 0; i < 86; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    depth = 16'd0;
                end else if (roll < 20) begin
                    depth = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
                end else begin
                    depth = 16'($urandom_range(1, 65535));
                end
                send_depth(depth);
            end
            settle();
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_invalid_calibration();
        test_field_extremes();
        test_zero_scale();
        test_unknown_index();
        test_size_change();
        test_max_dimension();
        test_full_stall();
        test_random_frames();
        settle();
        repeat (20) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            fails += pending_points.size();
            $display("%0t: %0d expected points never arrived", $time, pending_points.size());
        end
        $display("Sent %0d depth pixels over %0d register writes; checked %0d points.",
                 pixels_sent, cfg_writes, points_checked);
        $display("Covered invalid calibration, zero scale, size wrap and a full-queue stall.");
        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Timed out with %0d points outstanding.", pending_points.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

FILE: depth_pixel_backprojection_unit.f
+incdir+rtl
rtl/dpbu_pkg.sv
rtl/dpbu_front.sv
rtl/dpbu_cmd_queue.sv
rtl/dpbu_back.sv
rtl/depth_pixel_backprojection_unit.sv
test/tb_depth_pixel_backprojection_unit.sv
